### hw/rtl/mme_pkg.sv
// Shared types, codes and sizes of the matrix multiply engine.
package mme_pkg;

  localparam int MaxDimDef = 8;   // default largest matrix dimension
  localparam int IdxW      = 3;   // row / column index field width
  localparam int ElemW     = 16;  // Q8.8 element width
  localparam int ProdW     = 40;  // Q24.16 product element width
  localparam int StatW     = 2;
  localparam int CfgW      = 4;   // size register width
  localparam int DataW     = 32;  // APB data width
  localparam int AddrW     = 4;   // APB address width, four word registers

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_MUL   = 1'b1
  } req_e;

  typedef enum logic {
    SEL_A = 1'b0,
    SEL_B = 1'b1
  } sel_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK  = 2'd0,
    STAT_DIM = 2'd1,
    STAT_IDX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    wr_en;     // store the request's element
    logic    load_err;  // load an error result into the output register
    status_e err_code;
    logic    start;     // clear the product loop counters
    logic    issue;     // step one multiply-accumulate into the pipeline
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic adv;          // pipeline and output register may advance
    logic issue_last;   // counters sit on the final (i, j, k)
    logic pipe_busy;    // multiply-accumulate stages still hold work
    logic wr_oob;       // write indices outside the selected matrix
    logic dim_bad;      // A columns differ from B rows
  } sts_t;

endpackage

### hw/rtl/mme_in_if.sv
// Request channel of the matrix multiply engine.
interface mme_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic                              matrix_sel;
  logic        [mme_pkg::IdxW-1:0]   row_index;
  logic        [mme_pkg::IdxW-1:0]   col_index;
  logic signed [mme_pkg::ElemW-1:0]  elem_value;

  modport source (
    output valid, req_type, matrix_sel, row_index, col_index, elem_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, matrix_sel, row_index, col_index, elem_value,
    output ready
  );
endinterface

### hw/rtl/mme_out_if.sv
// Result channel of the matrix multiply engine.
interface mme_out_if;
  logic                              valid;
  logic                              ready;
  logic        [mme_pkg::IdxW-1:0]   out_row;
  logic        [mme_pkg::IdxW-1:0]   out_col;
  logic signed [mme_pkg::ProdW-1:0]  product_value;
  logic        [mme_pkg::StatW-1:0]  status;
  logic                              last;

  modport source (
    output valid, out_row, out_col, product_value, status, last,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, product_value, status, last,
    output ready
  );
endinterface

### hw/rtl/matrix_multiply_engine_unit.sv
// Matrix multiply engine top level: size registers, controller and datapath.
//
// Two row-major element stores, A and B (MaxDim x MaxDim signed Q8.8 each, row
// stride MaxDim), read as zero after reset through per-entry valid bits, so no
// clearing pass is needed and the block takes requests right out of reset. A
// write request stores one element and produces no result, or one
// index-error result (status 2, last set, position echoed) when the row or
// column is outside the selected matrix's configured size; writes can follow
// each other every cycle while the result port is free. A multiply request
// whose A column count differs from B's row count returns one dimension-error
// result (status 1). Otherwise the block walks i, j and then k, issuing one
// multiply-accumulate per cycle while the result port is free, against the
// single read port of each store, through the stages store read, 16x16
// multiply and accumulate into the output register. Products are
// full-precision Q24.16 in 40 bits and are emitted in
// row-major order with last set on the final element. Any cycle the result
// port stalls freezes the whole pipeline. Size registers (APB, byte address
// 4*index: a_rows, a_cols, b_rows, b_cols) read 0 as 1 and clamp above MaxDim;
// write them only while the block is idle.
module matrix_multiply_engine_unit #(
  parameter int MaxDim = mme_pkg::MaxDimDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mme_in_if.sink                     in_req,
  mme_out_if.source                  out_rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mme_pkg::AddrW-1:0]  paddr,
  input  logic [mme_pkg::DataW-1:0]  pwdata,
  output logic [mme_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  localparam int DW = $clog2(MaxDim + 1);

  // effective (clamped) dimensions
  logic [DW-1:0] a_rows, a_cols, b_rows, b_cols;

  // controller <-> datapath
  mme_pkg::cmd_t cmd;
  mme_pkg::sts_t sts;

  mme_regs #(
    .MaxDim (MaxDim)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .a_rows_o (a_rows),
    .a_cols_o (a_cols),
    .b_rows_o (b_rows),
    .b_cols_o (b_cols)
  );

  // request intake and sequencing
  mme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req.valid),
    .req_type_i (mme_pkg::req_e'(in_req.req_type)),
    .in_ready_o (in_req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores, MAC pipeline and result register
  mme_dp #(
    .MaxDim (MaxDim)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .a_rows_i        (a_rows),
    .a_cols_i        (a_cols),
    .b_rows_i        (b_rows),
    .b_cols_i        (b_cols),
    .matrix_sel_i    (mme_pkg::sel_e'(in_req.matrix_sel)),
    .row_index_i     (in_req.row_index),
    .col_index_i     (in_req.col_index),
    .elem_value_i    (in_req.elem_value),
    .out_valid_o     (out_rsp.valid),
    .out_ready_i     (out_rsp.ready),
    .out_row_o       (out_rsp.out_row),
    .out_col_o       (out_rsp.out_col),
    .product_value_o (out_rsp.product_value),
    .status_o        (out_rsp.status),
    .last_o          (out_rsp.last)
  );

endmodule

### hw/rtl/mme_regs.sv
// APB size registers and their clamped effective dimensions.
module mme_regs #(
  parameter int MaxDim = mme_pkg::MaxDimDef,
  localparam int DW    = $clog2(MaxDim + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mme_pkg::AddrW-1:0]  paddr,
  input  logic [mme_pkg::DataW-1:0]  pwdata,
  output logic [mme_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [DW-1:0]              a_rows_o,
  output logic [DW-1:0]              a_cols_o,
  output logic [DW-1:0]              b_rows_o,
  output logic [DW-1:0]              b_cols_o
);

  localparam logic [mme_pkg::CfgW-1:0] SizeRst = mme_pkg::CfgW'(8);

  logic [mme_pkg::CfgW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  mme_pkg::reg_e            reg_idx;

  // 0 acts as 1, anything above MaxDim acts as MaxDim
  function automatic logic [DW-1:0] eff_dim(input logic [mme_pkg::CfgW-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (int'(v) > MaxDim) begin
      r = DW'(MaxDim);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  assign reg_idx = mme_pkg::reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= SizeRst;
      a_cols_q <= SizeRst;
      b_rows_q <= SizeRst;
      b_cols_q <= SizeRst;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        mme_pkg::REG_A_ROWS: a_rows_q <= pwdata[mme_pkg::CfgW-1:0];
        mme_pkg::REG_A_COLS: a_cols_q <= pwdata[mme_pkg::CfgW-1:0];
        mme_pkg::REG_B_ROWS: b_rows_q <= pwdata[mme_pkg::CfgW-1:0];
        mme_pkg::REG_B_COLS: b_cols_q <= pwdata[mme_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mme_pkg::REG_A_ROWS: prdata = mme_pkg::DataW'(a_rows_q);
      mme_pkg::REG_A_COLS: prdata = mme_pkg::DataW'(a_cols_q);
      mme_pkg::REG_B_ROWS: prdata = mme_pkg::DataW'(b_rows_q);
      mme_pkg::REG_B_COLS: prdata = mme_pkg::DataW'(b_cols_q);
      default:             prdata = '0;
    endcase
  end

  assign a_rows_o = eff_dim(a_rows_q);
  assign a_cols_o = eff_dim(a_cols_q);
  assign b_rows_o = eff_dim(b_rows_q);
  assign b_cols_o = eff_dim(b_cols_q);

endmodule

### hw/rtl/mme_ctrl.sv
// Controller state machine: request intake and multiply sequencing.
module mme_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  mme_pkg::req_e req_type_i,
  output logic          in_ready_o,
  input  mme_pkg::sts_t sts_i,
  output mme_pkg::cmd_t cmd_o
);

  mme_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mme_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mme_pkg::ST_IDLE: begin
        if (accept && req_type_i == mme_pkg::REQ_MUL && !sts_i.dim_bad) begin
          state_d = mme_pkg::ST_RUN;
        end
      end
      mme_pkg::ST_RUN: begin
        if (sts_i.adv && sts_i.issue_last) begin
          state_d = mme_pkg::ST_FLUSH;
        end
      end
      mme_pkg::ST_FLUSH: begin
        if (!sts_i.pipe_busy) begin
          state_d = mme_pkg::ST_IDLE;
        end
      end
      default: state_d = mme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.wr_en     = 1'b0;
    cmd_o.load_err  = 1'b0;
    cmd_o.err_code  = mme_pkg::STAT_OK;
    cmd_o.start     = 1'b0;
    cmd_o.issue     = 1'b0;
    case (state_q)
      mme_pkg::ST_IDLE: begin
        // an error result needs the output register free
        in_ready_o = sts_i.adv;
        if (req_type_i == mme_pkg::REQ_WRITE) begin
          cmd_o.wr_en    = accept && !sts_i.wr_oob;
          cmd_o.load_err = accept && sts_i.wr_oob;
          cmd_o.err_code = mme_pkg::STAT_IDX;
        end else begin
          cmd_o.start    = accept && !sts_i.dim_bad;
          cmd_o.load_err = accept && sts_i.dim_bad;
          cmd_o.err_code = mme_pkg::STAT_DIM;
        end
      end
      mme_pkg::ST_RUN: cmd_o.issue = 1'b1;
      mme_pkg::ST_FLUSH: ;
      default: ;
    endcase
  end

endmodule

### hw/rtl/mme_dp.sv
// Datapath: element stores, loop counters, MAC pipeline, output register.
module mme_dp #(
  parameter int MaxDim = mme_pkg::MaxDimDef,
  localparam int DW    = $clog2(MaxDim + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mme_pkg::cmd_t                     cmd_i,
  output mme_pkg::sts_t                     sts_o,
  input  logic [DW-1:0]                     a_rows_i,
  input  logic [DW-1:0]                     a_cols_i,
  input  logic [DW-1:0]                     b_rows_i,
  input  logic [DW-1:0]                     b_cols_i,
  input  mme_pkg::sel_e                     matrix_sel_i,
  input  logic        [mme_pkg::IdxW-1:0]   row_index_i,
  input  logic        [mme_pkg::IdxW-1:0]   col_index_i,
  input  logic signed [mme_pkg::ElemW-1:0]  elem_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic        [mme_pkg::IdxW-1:0]   out_row_o,
  output logic        [mme_pkg::IdxW-1:0]   out_col_o,
  output logic signed [mme_pkg::ProdW-1:0]  product_value_o,
  output logic        [mme_pkg::StatW-1:0]  status_o,
  output logic                              last_o
);

  localparam int Depth = MaxDim * MaxDim;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int CmpW  = ((DW > mme_pkg::IdxW) ? DW : mme_pkg::IdxW) + 1;
  localparam int EW    = mme_pkg::ElemW;
  localparam int PW    = 2 * mme_pkg::ElemW;

  // write side
  logic [DW-1:0] lim_rows, lim_cols;
  logic [AW-1:0] wr_addr;
  logic          wr_a, wr_b;

  // loop counters
  logic [CW-1:0] i_q, j_q, k_q;
  logic          k_last, j_last, i_last;
  logic          adv;

  // stores: valid bits stand in for the reset clear
  logic [EW-1:0]    mem_a [Depth];
  logic [EW-1:0]    mem_b [Depth];
  logic [Depth-1:0] vld_a_q, vld_b_q;
  logic [AW-1:0]    rd_addr_a, rd_addr_b;

  // stage 1: read data
  logic [EW-1:0]        rd_a_q, rd_b_q;
  logic                 rv_a_q, rv_b_q;
  logic                 s1_v_q, s1_first_q, s1_klast_q, s1_last_q;
  logic [CW-1:0]        s1_i_q, s1_j_q;
  logic signed [EW-1:0] op_a, op_b;

  // stage 2: product
  logic signed [PW-1:0] p_q;
  logic                 s2_v_q, s2_first_q, s2_klast_q, s2_last_q;
  logic [CW-1:0]        s2_i_q, s2_j_q;

  // accumulate
  logic signed [mme_pkg::ProdW-1:0] p_ext, acc_q, sum;
  logic                             load_res;

  // output register
  logic                             out_vld_q;
  logic        [mme_pkg::IdxW-1:0]  out_row_q, out_col_q;
  logic signed [mme_pkg::ProdW-1:0] out_val_q;
  logic        [mme_pkg::StatW-1:0] out_stat_q;
  logic                             out_last_q;

  assign adv = !out_vld_q || out_ready_i;

  // ---- write check and address
  assign lim_rows = (matrix_sel_i == mme_pkg::SEL_B) ? b_rows_i : a_rows_i;
  assign lim_cols = (matrix_sel_i == mme_pkg::SEL_B) ? b_cols_i : a_cols_i;
  assign wr_addr  = AW'(row_index_i) * AW'(MaxDim) + AW'(col_index_i);
  assign wr_a     = cmd_i.wr_en && matrix_sel_i == mme_pkg::SEL_A;
  assign wr_b     = cmd_i.wr_en && matrix_sel_i == mme_pkg::SEL_B;

  // ---- counters, row-major over (i, j) with k innermost
  assign k_last = DW'(k_q) == (a_cols_i - DW'(1));
  assign j_last = DW'(j_q) == (b_cols_i - DW'(1));
  assign i_last = DW'(i_q) == (a_rows_i - DW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (cmd_i.start) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (cmd_i.issue && adv) begin
      if (k_last) begin
        k_q <= '0;
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end else begin
        k_q <= k_q + CW'(1);
      end
    end
  end

  assign rd_addr_a = AW'(i_q) * AW'(MaxDim) + AW'(k_q);
  assign rd_addr_b = AW'(k_q) * AW'(MaxDim) + AW'(j_q);

  // ---- stores
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[wr_addr] <= elem_value_i;
    end
    if (adv) begin
      rd_a_q <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[wr_addr] <= elem_value_i;
    end
    if (adv) begin
      rd_b_q <= mem_b[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
    end else begin
      if (wr_a) begin
        vld_a_q[wr_addr] <= 1'b1;
      end
      if (wr_b) begin
        vld_b_q[wr_addr] <= 1'b1;
      end
    end
  end

  // ---- pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_a_q <= 1'b0;
      rv_b_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      rv_a_q <= vld_a_q[rd_addr_a];
      rv_b_q <= vld_b_q[rd_addr_b];
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
    end
  end

  assign op_a = rv_a_q ? rd_a_q : '0;
  assign op_b = rv_b_q ? rd_b_q : '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_first_q <= k_q == '0;
      s1_klast_q <= k_last;
      s1_last_q  <= i_last && j_last;
      s1_i_q     <= i_q;
      s1_j_q     <= j_q;
      p_q        <= op_a * op_b;
      s2_first_q <= s1_first_q;
      s2_klast_q <= s1_klast_q;
      s2_last_q  <= s1_last_q;
      s2_i_q     <= s1_i_q;
      s2_j_q     <= s1_j_q;
    end
  end

  // ---- accumulate; the final k of an element goes straight to the output
  assign p_ext    = mme_pkg::ProdW'(p_q);
  assign sum      = s2_first_q ? p_ext : acc_q + p_ext;
  assign load_res = adv && s2_v_q && s2_klast_q;

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      acc_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_res || cmd_i.load_err) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_row_q  <= mme_pkg::IdxW'(s2_i_q);
      out_col_q  <= mme_pkg::IdxW'(s2_j_q);
      out_val_q  <= sum;
      out_stat_q <= mme_pkg::STAT_OK;
      out_last_q <= s2_last_q;
    end else if (cmd_i.load_err) begin
      // index error echoes the request's position, dimension error gives zero
      if (cmd_i.err_code == mme_pkg::STAT_IDX) begin
        out_row_q <= row_index_i;
        out_col_q <= col_index_i;
      end else begin
        out_row_q <= '0;
        out_col_q <= '0;
      end
      out_val_q  <= '0;
      out_stat_q <= cmd_i.err_code;
      out_last_q <= 1'b1;
    end
  end

  // ---- status to controller
  assign sts_o.adv        = adv;
  assign sts_o.issue_last = k_last && j_last && i_last;
  assign sts_o.pipe_busy  = s1_v_q || s2_v_q;
  assign sts_o.wr_oob     = (CmpW'(row_index_i) >= CmpW'(lim_rows)) ||
                            (CmpW'(col_index_i) >= CmpW'(lim_cols));
  assign sts_o.dim_bad    = a_cols_i != b_rows_i;

  assign out_valid_o     = out_vld_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = out_val_q;
  assign status_o        = out_stat_q;
  assign last_o          = out_last_q;

endmodule

### hw/rtl/mme_checker.sv
// Port-level assertions for the matrix multiply engine, bound to the top level.
module mme_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [mme_pkg::ProdW-1:0]  out_value_i,
  input logic        [mme_pkg::StatW-1:0]  out_status_i,
  input logic                              out_last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_value_i) && $stable(out_status_i) && $stable(out_last_i))
  else $error("result changed while stalled");

  // error results are single and end their request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != mme_pkg::STAT_OK |-> out_last_i)
  else $error("error result without last");

  // error results carry no product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != mme_pkg::STAT_OK |-> out_value_i == '0)
  else $error("error result with nonzero product");

  // while a multiply still has elements to go, no request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
  else $error("request taken in the middle of a multiply");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_req.valid),
  .in_ready_i   (in_req.ready),
  .out_valid_i  (out_rsp.valid),
  .out_ready_i  (out_rsp.ready),
  .out_value_i  (out_rsp.product_value),
  .out_status_i (out_rsp.status),
  .out_last_i   (out_rsp.last)
);
